@@ src/keyed_sum_aggregator_defines.svh @@
// ----------------------------------------------------------------------------
// keyed sum aggregator assertion macros
// concurrent checks, compiled away for synthesis
// ----------------------------------------------------------------------------
`ifndef KEYED_SUM_AGGREGATOR_DEFINES_SVH
`define KEYED_SUM_AGGREGATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed sum aggregator check failed");

// next-cycle implication
`define KSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed sum aggregator check failed");

`else

`define KSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/ksa_pkg.sv @@
// ----------------------------------------------------------------------------
// ksa_pkg
// shared types, sizes and helpers of the keyed sum aggregator
// ----------------------------------------------------------------------------
`default_nettype none

package ksa_pkg;

    // table size and derived widths
    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // front-to-back queue, power of two entries
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic signed [31:0] key;
        logic signed [31:0] quantity;
        logic signed [31:0] amount;
    } t_in;

    typedef struct packed {
        logic              entry_valid;
        logic signed [31:0] out_key;
        logic signed [31:0] total_quantity;
        logic signed [31:0] total_amount;
        logic              dropped;
        logic              last;
    } t_out;

    typedef enum logic [0:0] {
        OP_RECORD,
        OP_DUMP
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic signed [31:0] key;
        logic signed [31:0] quantity;
        logic signed [31:0] amount;
    } t_op;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] qsum;
        logic signed [31:0] asum;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ADD,
        S_MARK,
        S_DRD,
        S_DLOAD
    } t_back_state;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            r = s[32] ? SAT_MIN : SAT_MAX;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/ksa_front.sv @@
// ----------------------------------------------------------------------------
// ksa_front
// input register stage, decodes each transaction into a table operation
// ----------------------------------------------------------------------------
`default_nettype none

module ksa_front import ksa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_q_valid,
    input  wire logic i_q_ready,
    output t_op       o_q_data
);

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    t_op  n_op;

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_data   = r_op;

    // dump ignores the payload fields
    always_comb begin
        n_op = r_op;
        unique case (i_in_data.mode)
            MODE_RECORD: begin
                n_op.kind     = OP_RECORD;
                n_op.key      = i_in_data.key;
                n_op.quantity = i_in_data.quantity;
                n_op.amount   = i_in_data.amount;
            end
            MODE_DUMP: begin
                n_op.kind     = OP_DUMP;
                n_op.key      = '0;
                n_op.quantity = '0;
                n_op.amount   = '0;
            end
            default: begin
                n_op.kind = OP_RECORD;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (i_in_valid && o_in_ready) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op <= n_op;
        end
    end

endmodule

`default_nettype wire

@@ src/ksa_queue.sv @@
// ----------------------------------------------------------------------------
// ksa_queue
// short fifo of table operations between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ksa_queue import ksa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_op  i_push_data,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_op       o_pop_data
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers wrap on their own since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/ksa_back.sv @@
// ----------------------------------------------------------------------------
// ksa_back
// table engine: key search, saturating update, insert and dump sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_sum_aggregator_defines.svh"

module ksa_back import ksa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_valid,
    output logic      o_op_ready,
    input  wire t_op  i_op_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic             r_drop;
    logic             n_drop;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out             r_out;
    t_out             n_out;
    t_op              r_op;
    logic             op_take;
    logic             out_free;
    logic             load_out;
    logic             dump_last;

    // entry memory, one write and one registered read port
    t_entry            r_mem [DEPTH];
    t_entry            r_rd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    assign o_op_ready  = r_state == S_IDLE;
    assign op_take     = i_op_valid && o_op_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;
    assign dump_last   = (r_idx + CNT_W'(1)) == r_used;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[ADDR_W-1:0];
        mem_wdata   = r_rd;
        mem_re      = 1'b0;
        mem_raddr   = r_idx[ADDR_W-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (op_take) begin
                    if (i_op_data.kind == OP_DUMP) begin
                        n_state = (r_used == '0) ? S_MARK : S_DRD;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_idx == r_used) begin
                    if (r_used < CNT_W'(DEPTH)) begin
                        mem_we         = 1'b1;
                        mem_waddr      = r_used[ADDR_W-1:0];
                        mem_wdata.key  = r_op.key;
                        mem_wdata.qsum = r_op.quantity;
                        mem_wdata.asum = r_op.amount;
                        n_used         = r_used + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_rd.key == r_op.key) begin
                    n_state = S_ADD;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_ADD: begin
                mem_we         = 1'b1;
                mem_wdata.key  = r_rd.key;
                mem_wdata.qsum = sat_add32(r_rd.qsum, r_op.quantity);
                mem_wdata.asum = sat_add32(r_rd.asum, r_op.amount);
                n_state        = S_IDLE;
            end
            S_MARK: begin
                if (out_free) begin
                    load_out             = 1'b1;
                    n_out_valid          = 1'b1;
                    n_out.entry_valid    = 1'b0;
                    n_out.out_key        = '0;
                    n_out.total_quantity = '0;
                    n_out.total_amount   = '0;
                    n_out.dropped        = r_drop;
                    n_out.last           = 1'b1;
                    n_used               = '0;
                    n_drop               = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            S_DRD: begin
                mem_re  = 1'b1;
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                if (out_free) begin
                    load_out             = 1'b1;
                    n_out_valid          = 1'b1;
                    n_out.entry_valid    = 1'b1;
                    n_out.out_key        = r_rd.key;
                    n_out.total_quantity = r_rd.qsum;
                    n_out.total_amount   = r_rd.asum;
                    n_out.dropped        = r_drop;
                    n_out.last           = dump_last;
                    if (dump_last) begin
                        n_used  = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op_take) begin
            r_op <= i_op_data;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    `KSA_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(DEPTH))
    `KSA_ASSERT_IMPL(a_scan_in_table, i_clk, i_rst_n, r_state == S_CMP || r_state == S_DLOAD, r_idx < r_used)
    `KSA_ASSERT_IMPL(a_marker_is_last, i_clk, i_rst_n, r_out_valid && !r_out.entry_valid, r_out.last)
    `KSA_ASSERT_NEXT(a_dump_clears, i_clk, i_rst_n, load_out && n_out.last, r_used == '0 && !r_drop)

endmodule

`default_nettype wire

@@ src/keyed_sum_aggregator.sv @@
// a record passes the front register and the queue, then the engine reads and compares the stored entries in turn
// and adds on a hit or inserts at the end; the engine takes no new operation until the record is stored or dropped
// a dump reads each entry through the single read port of the entry memory before it loads the output register
// an empty-table dump gives only its marker, with entry_valid low and last set
// reset: synchronous, active low; the table is empty and the drop flag clear at once
// ----------------------------------------------------------------------------
// keyed_sum_aggregator
// group-by table that sums quantity and amount per key, dumped in insertion order
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_sum_aggregator import ksa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // input transactions: record or dump
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    // result transactions of a dump
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    // front to queue
    logic f_valid;
    logic f_ready;
    t_op  f_data;
    // queue to back
    logic q_valid;
    logic q_ready;
    t_op  q_data;

    // front: registers and decodes incoming transactions
    ksa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (f_valid),
        .i_q_ready  (f_ready),
        .o_q_data   (f_data)
    );

    // short queue lets the front keep taking transactions while the engine scans
    ksa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_data),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    // back: sequential key search, saturating update, insert and dump
    // results leave through an output register so a stalled sink does not
    // hold up the scan until the next result is ready
    ksa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .o_op_ready  (q_ready),
        .i_op_data   (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
